/* rtl/bdeque_pkg.sv */
// Shared types and constants for the bounded array deque.
// No dependencies; bdeque_ctrl, bdeque_dp and the top level refer to this package by scoped name.
`timescale 1ns / 1ps

package bdeque_pkg;

  // Port field widths
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Request codes carried by mode
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_RIGHT = 2'd0,
    MODE_INS_LEFT  = 2'd1,
    MODE_DEL_RIGHT = 2'd2,
    MODE_DEL_LEFT  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;  // take the input word and update pointers
    logic load;  // move the pending result into the output register
  } cmd_t;

endpackage

/* rtl/bdeque_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bdeque_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bdeque_ctrl.sv */
// Controller for the bounded array deque: two-state sequencer and output valid.
// Depends on bdeque_pkg (cmd_t).
`timescale 1ns / 1ps

module bdeque_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bdeque_pkg::cmd_t  cmd
);

  typedef enum logic {
    IDLE,
    PEND
  } state_t;

  state_t state;

  // Take a word only when no result is pending in the datapath
  assign in_stall = (state != IDLE);

  // Step on an accepted word; load once the output register is free
  assign cmd.step = in_valid && (state == IDLE);
  assign cmd.load = (state == PEND) && (!out_valid || !out_stall);

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.step) begin
            state <= PEND;
          end
        end
        PEND: begin
          if (cmd.load) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted word always leaves a pending result
  a_step_pends: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (state == PEND))
    else $error("accepted word did not enter pending state");

  // A loaded result shows up at the output
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  // A pending result waits while the output register is blocked
  a_pend_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == PEND) && out_valid && out_stall) |=> (state == PEND))
    else $error("pending result dropped while output blocked");

  // Never step and load in the same cycle
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.load))
    else $error("step and load overlap");

endmodule

/* rtl/bdeque_dp.sv */
// Datapath for the bounded array deque: end pointers, slot RAM, result registers.
// Depends on bdeque_pkg and bdeque_ram.
`timescale 1ns / 1ps

module bdeque_dp #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bdeque_pkg::cmd_t                    cmd,
  input  logic [bdeque_pkg::MODE_W-1:0]       mode,
  input  logic [bdeque_pkg::DATA_W-1:0]       data_in,
  output logic [bdeque_pkg::STAT_W-1:0]       status,
  output logic [bdeque_pkg::DATA_W-1:0]       data_out,
  output logic [bdeque_pkg::OCC_W-1:0]        occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  bdeque_pkg::mode_t   req;
  bdeque_pkg::status_t stat_next;

  // Pointer state
  logic [IDX_W-1:0] lidx, lidx_next;
  logic [IDX_W-1:0] ridx, ridx_next;
  logic             empty, empty_next;

  // Pending result
  logic [bdeque_pkg::STAT_W-1:0] pend_status;
  logic [bdeque_pkg::OCC_W-1:0]  pend_occ;
  logic                          pend_rd, rd_next;

  // RAM access
  logic                 we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [WORD_BITS-1:0] word, rdata;

  // Width adaptation between the 32-bit ports and the stored word
  logic [WORD_BITS+bdeque_pkg::DATA_W-1:0] in_ext, rd_ext;
  logic [IDX_W:0]                          occ_sum;
  logic [IDX_W+bdeque_pkg::OCC_W:0]        occ_ext;

  assign req    = bdeque_pkg::mode_t'(mode);
  assign in_ext = {{WORD_BITS{1'b0}}, data_in};
  assign word   = in_ext[WORD_BITS-1:0];
  assign rd_ext = {{bdeque_pkg::DATA_W{1'b0}}, rdata};

  // Decide status, pointer moves and the RAM access for one request
  always_comb begin
    lidx_next  = lidx;
    ridx_next  = ridx;
    empty_next = empty;
    stat_next  = bdeque_pkg::ST_DONE;
    rd_next    = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = '0;
    raddr      = ridx;
    case (req)
      bdeque_pkg::MODE_INS_RIGHT, bdeque_pkg::MODE_INS_LEFT: begin
        if (empty) begin
          lidx_next  = '0;
          ridx_next  = '0;
          empty_next = 1'b0;
          we         = cmd.step;
        end else if (req == bdeque_pkg::MODE_INS_RIGHT) begin
          if (ridx == LAST) begin
            stat_next = bdeque_pkg::ST_NO_ROOM;
          end else begin
            ridx_next = ridx + 1'b1;
            waddr     = ridx + 1'b1;
            we        = cmd.step;
          end
        end else begin
          if (lidx == '0) begin
            stat_next = bdeque_pkg::ST_NO_ROOM;
          end else begin
            lidx_next = lidx - 1'b1;
            waddr     = lidx - 1'b1;
            we        = cmd.step;
          end
        end
      end
      bdeque_pkg::MODE_DEL_RIGHT, bdeque_pkg::MODE_DEL_LEFT: begin
        if (empty) begin
          stat_next = bdeque_pkg::ST_EMPTY;
        end else begin
          rd_next = 1'b1;
          re      = cmd.step;
          raddr   = (req == bdeque_pkg::MODE_DEL_RIGHT) ? ridx : lidx;
          if (lidx == ridx) begin
            lidx_next  = '0;
            ridx_next  = '0;
            empty_next = 1'b1;
          end else if (req == bdeque_pkg::MODE_DEL_RIGHT) begin
            ridx_next = ridx - 1'b1;
          end else begin
            lidx_next = lidx + 1'b1;
          end
        end
      end
      default: begin
        stat_next = bdeque_pkg::ST_DONE;
      end
    endcase
  end

  // Occupancy after the step
  assign occ_sum = {1'b0, ridx_next} - {1'b0, lidx_next} + 1'b1;
  assign occ_ext = empty_next ? '0 : (IDX_W+bdeque_pkg::OCC_W+1)'(occ_sum);

  // Advance pointers on a step
  always_ff @(posedge clk) begin
    if (rst) begin
      lidx  <= '0;
      ridx  <= '0;
      empty <= 1'b1;
    end else if (cmd.step) begin
      lidx  <= lidx_next;
      ridx  <= ridx_next;
      empty <= empty_next;
    end
  end

  // Capture the pending result
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_status <= stat_next;
      pend_occ    <= occ_ext[bdeque_pkg::OCC_W-1:0];
      pend_rd     <= rd_next;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status    <= pend_status;
      occupancy <= pend_occ;
      data_out  <= pend_rd ? rd_ext[bdeque_pkg::DATA_W-1:0] : '0;
    end
  end

  bdeque_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (word),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // An empty deque keeps both pointers at slot 0
  a_empty_home: assert property (@(posedge clk) disable iff (rst)
    empty |-> ((lidx == '0) && (ridx == '0)))
    else $error("empty deque with pointers away from slot 0");

  // Stored words never run right to left
  a_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (lidx <= ridx))
    else $error("left pointer passed right pointer");

endmodule

/* rtl/bounded_array_deque_top.sv */
// Top level of the bounded array deque: controller plus datapath.
// Depends on bdeque_pkg, bdeque_ctrl, bdeque_dp (and bdeque_ram below it).
//
//   Channel  Handshake            Fields
//   in       in_valid / in_stall  mode, data_in
//   out      out_valid / out_stall status, data_out, occupancy
//
// Each word first updates the pointers and starts the slot RAM access; the
// registered RAM read then completes before the result is loaded.
// Reset (rst, synchronous) empties the deque at once; no clearing pass.
// A new word is taken while an earlier result still sits in the output register.
// A stalled output holds the result and the next result waits in the datapath.
`timescale 1ns / 1ps

module bounded_array_deque_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdeque_pkg::MODE_W-1:0] mode,
  input  logic [bdeque_pkg::DATA_W-1:0] data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdeque_pkg::STAT_W-1:0] status,
  output logic [bdeque_pkg::DATA_W-1:0] data_out,
  output logic [bdeque_pkg::OCC_W-1:0]  occupancy
);

  bdeque_pkg::cmd_t cmd;

  bdeque_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bdeque_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mode      (mode),
    .data_in   (data_in),
    .status    (status),
    .data_out  (data_out),
    .occupancy (occupancy)
  );

endmodule
